// ===== rtl/rbfi_pkg.sv =====
package rbfi_pkg;

    // Axis and face-plane counts.
    localparam int AXES   = 3;
    localparam int PLANES = 2 * AXES;

    // Field widths of the ports.
    localparam int COORD_W = 32;
    localparam int SIZE_W  = 31;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 5;

    // Internal widths: coordinates are held doubled so that the bounds are exact.
    localparam int O2_W   = COORD_W + 1;     // doubled origin or direction
    localparam int BND_W  = COORD_W + 2;     // doubled box bound
    localparam int DIFF_W = BND_W + 1;       // plane minus doubled origin
    localparam int MAG_W  = BND_W;           // magnitude of that difference
    localparam int TSHIFT = 16;              // fraction bits of t
    localparam int NUM_W  = MAG_W + TSHIFT;  // dividend
    localparam int DEN_W  = O2_W;            // divisor magnitude
    localparam int REM_W  = DEN_W;           // partial remainder
    localparam int QUO_W  = NUM_W;           // quotient magnitude
    localparam int ACC_W  = REM_W + NUM_W;   // remainder and dividend together
    localparam int TL_W   = 32;              // low half of t
    localparam int TH_W   = QUO_W - TL_W;    // high half of t
    localparam int HI_W   = DEN_W + TH_W;    // product with the high half
    localparam int LO_W   = DEN_W + TL_W;    // product with the low half
    localparam int PROD_W = 64;              // the low product never exceeds this
    localparam int OFF_W  = 57;              // offset magnitude
    localparam int PT_W   = 60;              // crossing point coordinate

    // Far crossings saturate their offset to a value outside every box.
    localparam int               LIMIT_LOG = 40;
    localparam logic [OFF_W-1:0] OFF_SAT   = OFF_W'(64'd281474976710656);

    // Register indexes.
    localparam logic [2:0] REG_SIZE_X   = 3'd0;
    localparam logic [2:0] REG_SIZE_Y   = 3'd1;
    localparam logic [2:0] REG_SIZE_Z   = 3'd2;
    localparam logic [2:0] REG_CENTRE_X = 3'd3;
    localparam logic [2:0] REG_CENTRE_Y = 3'd4;
    localparam logic [2:0] REG_CENTRE_Z = 3'd5;

    // Box bounds derived from the configuration.
    typedef struct packed {
        logic [AXES-1:0][BND_W-1:0] lo;
        logic [AXES-1:0][BND_W-1:0] hi;
        logic [AXES-1:0]            size_nz;
    } t_bounds;

    // Per-ray data that travels alongside the dividers.
    typedef struct packed {
        logic [AXES-1:0][O2_W-1:0]  org2;
        logic [AXES-1:0][DEN_W-1:0] dmag;
        logic [AXES-1:0]            dneg;
        logic [PLANES-1:0]          pen;
    } t_side;

endpackage

// ===== rtl/ray_box_face_intersection_core.sv =====
// Ray versus axis-aligned box face test.
// Input channel: i_valid / o_stall carry one ray per transaction (origin and
// direction, Q16.16). Output channel: o_valid / i_stall carry one hit bit per
// ray, in the order the rays arrived.
// The box (size and centre per axis) is to be set by the user through the APB-style
// port only while no ray is in flight; the block itself does not enforce this.
// Register i sits at byte address 4*i. A ray passes through input capture,
// divider load, the 50-stage restoring divider that forms the crossing parameter
// of each face plane (one quotient bit per stage), two multiply stages and the
// compare stage. Throughput is one ray per cycle while no held result stalls it.
// Reset clears the box registers to zero and empties the pipeline.
// While a result waits with i_stall high, the whole pipeline holds and
// o_stall is raised; nothing is dropped or repeated.
module ray_box_face_intersection_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [rbfi_pkg::COORD_W-1:0]  i_start_x,
    input  logic [rbfi_pkg::COORD_W-1:0]  i_start_y,
    input  logic [rbfi_pkg::COORD_W-1:0]  i_start_z,
    input  logic [rbfi_pkg::COORD_W-1:0]  i_dir_x,
    input  logic [rbfi_pkg::COORD_W-1:0]  i_dir_y,
    input  logic [rbfi_pkg::COORD_W-1:0]  i_dir_z,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_hit,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rbfi_pkg::ADDR_W-1:0]   paddr,
    input  logic [rbfi_pkg::DATA_W-1:0]   pwdata,
    output logic [rbfi_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import rbfi_pkg::*;

    t_bounds                       bnd;
    logic                          en;
    logic                          prep_v;
    t_side                         prep_side;
    logic [PLANES-1:0][NUM_W-1:0]  num;
    logic [PLANES-1:0][DEN_W-1:0]  den;
    logic [PLANES-1:0]             neg;
    logic [PLANES-1:0][QUO_W-1:0]  tmag;
    logic [PLANES-1:0]             tneg;
    logic                          r_vld  [QUO_W+1];
    t_side                         r_side [QUO_W+1];

    // The pipeline advances unless a finished result is held by the receiver.
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    rbfi_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_bnd   (bnd)
    );

    rbfi_prep u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_valid),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_start_z (i_start_z),
        .i_dir_x   (i_dir_x),
        .i_dir_y   (i_dir_y),
        .i_dir_z   (i_dir_z),
        .i_bnd     (bnd),
        .o_valid   (prep_v),
        .o_side    (prep_side),
        .o_num     (num),
        .o_den     (den),
        .o_neg     (neg)
    );

    // One divider per face plane.
    for (genvar p = 0; p < PLANES; p++) begin : g_div
        rbfi_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (num[p]),
            .i_den (den[p]),
            .i_neg (neg[p]),
            .o_quo (tmag[p]),
            .o_neg (tneg[p])
        );
    end

    // Valid bits and per-ray data kept in step with the dividers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QUO_W; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= prep_v;
            for (int k = 1; k <= QUO_W; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= prep_side;
            for (int k = 1; k <= QUO_W; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    rbfi_point u_point (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vld[QUO_W]),
        .i_side  (r_side[QUO_W]),
        .i_tmag  (tmag),
        .i_tneg  (tneg),
        .i_bnd   (bnd),
        .o_valid (o_valid),
        .o_hit   (o_hit)
    );

endmodule

// ===== rtl/rbfi_regs.sv =====
module rbfi_regs (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [rbfi_pkg::ADDR_W-1:0] paddr,
    input  logic [rbfi_pkg::DATA_W-1:0] pwdata,
    output logic [rbfi_pkg::DATA_W-1:0] prdata,
    output logic                     pready,
    output rbfi_pkg::t_bounds        o_bnd
);
    import rbfi_pkg::*;

    logic [SIZE_W-1:0]  r_size   [AXES];
    logic [COORD_W-1:0] r_centre [AXES];
    logic [2:0]         idx;
    logic               wr;

    assign idx    = paddr[4:2];
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;

    // Register writes complete in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                r_size[a]   <= '0;
                r_centre[a] <= '0;
            end
        end else if (wr) begin
            case (idx)
                REG_SIZE_X:   r_size[0]   <= pwdata[SIZE_W-1:0];
                REG_SIZE_Y:   r_size[1]   <= pwdata[SIZE_W-1:0];
                REG_SIZE_Z:   r_size[2]   <= pwdata[SIZE_W-1:0];
                REG_CENTRE_X: r_centre[0] <= pwdata;
                REG_CENTRE_Y: r_centre[1] <= pwdata;
                REG_CENTRE_Z: r_centre[2] <= pwdata;
                default: ;
            endcase
        end
    end

    // Read data.
    always_comb begin
        case (idx)
            REG_SIZE_X:   prdata = {1'b0, r_size[0]};
            REG_SIZE_Y:   prdata = {1'b0, r_size[1]};
            REG_SIZE_Z:   prdata = {1'b0, r_size[2]};
            REG_CENTRE_X: prdata = r_centre[0];
            REG_CENTRE_Y: prdata = r_centre[1];
            REG_CENTRE_Z: prdata = r_centre[2];
            default:      prdata = '0;
        endcase
    end

    // Doubled bounds: twice the centre minus or plus the size.
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            o_bnd.lo[a] = {r_centre[a][COORD_W-1], r_centre[a], 1'b0}
                          - {3'b000, r_size[a]};
            o_bnd.hi[a] = {r_centre[a][COORD_W-1], r_centre[a], 1'b0}
                          + {3'b000, r_size[a]};
            o_bnd.size_nz[a] = |r_size[a];
        end
    end

endmodule

// ===== rtl/rbfi_prep.sv =====
module rbfi_prep (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [rbfi_pkg::COORD_W-1:0]  i_start_x,
    input  logic [rbfi_pkg::COORD_W-1:0]  i_start_y,
    input  logic [rbfi_pkg::COORD_W-1:0]  i_start_z,
    input  logic [rbfi_pkg::COORD_W-1:0]  i_dir_x,
    input  logic [rbfi_pkg::COORD_W-1:0]  i_dir_y,
    input  logic [rbfi_pkg::COORD_W-1:0]  i_dir_z,
    input  rbfi_pkg::t_bounds             i_bnd,
    output logic                          o_valid,
    output rbfi_pkg::t_side               o_side,
    output logic [rbfi_pkg::PLANES-1:0][rbfi_pkg::NUM_W-1:0] o_num,
    output logic [rbfi_pkg::PLANES-1:0][rbfi_pkg::DEN_W-1:0] o_den,
    output logic [rbfi_pkg::PLANES-1:0]   o_neg
);
    import rbfi_pkg::*;

    logic               r_v;
    logic [COORD_W-1:0] r_start [AXES];
    logic [COORD_W-1:0] r_dir   [AXES];
    logic [O2_W-1:0]    dir2    [AXES];
    logic [AXES-1:0]    dnz;

    // Input capture register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_start[0] <= i_start_x;
            r_start[1] <= i_start_y;
            r_start[2] <= i_start_z;
            r_dir[0]   <= i_dir_x;
            r_dir[1]   <= i_dir_y;
            r_dir[2]   <= i_dir_z;
        end
    end

    assign o_valid = r_v;

    // Doubled origin and direction, direction magnitude and sign.
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            o_side.org2[a] = {r_start[a], 1'b0};
            dir2[a]        = {r_dir[a], 1'b0};
            o_side.dneg[a] = r_dir[a][COORD_W-1];
            o_side.dmag[a] = o_side.dneg[a] ? (~dir2[a] + 1'b1) : dir2[a];
            dnz[a]         = |r_dir[a];
        end
    end

    // Per face plane: signed distance to the plane, scaled, split into sign and magnitude.
    for (genvar p = 0; p < PLANES; p++) begin : g_plane
        logic [BND_W-1:0]  plane;
        logic [DIFF_W-1:0] diff;
        logic [DIFF_W-1:0] mag;

        always_comb begin
            plane = ((p % 2) != 0) ? i_bnd.hi[p/2] : i_bnd.lo[p/2];
            diff  = {plane[BND_W-1], plane}
                    - {{2{o_side.org2[p/2][O2_W-1]}}, o_side.org2[p/2]};
            mag   = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
            o_num[p] = {mag[MAG_W-1:0], {TSHIFT{1'b0}}};
            o_den[p] = o_side.dmag[p/2];
            o_neg[p] = diff[DIFF_W-1] ^ o_side.dneg[p/2];
            o_side.pen[p] = dnz[p/2] & i_bnd.size_nz[p/2];
        end
    end

endmodule

// ===== rtl/rbfi_div.sv =====
module rbfi_div (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [rbfi_pkg::NUM_W-1:0]   i_num,
    input  logic [rbfi_pkg::DEN_W-1:0]   i_den,
    input  logic                         i_neg,
    output logic [rbfi_pkg::QUO_W-1:0]   o_quo,
    output logic                         o_neg
);
    import rbfi_pkg::*;

    logic [ACC_W-1:0] r_acc [QUO_W+1];
    logic [DEN_W-1:0] r_den [QUO_W+1];
    logic             r_neg [QUO_W+1];

    // Load stage: remainder cleared, dividend in the low bits.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc[0] <= {{REM_W{1'b0}}, i_num};
            r_den[0] <= i_den;
            r_neg[0] <= i_neg;
        end
    end

    // One restoring step per stage, one quotient bit each.
    for (genvar k = 1; k <= QUO_W; k++) begin : g_step
        logic [ACC_W:0]   sh;
        logic [REM_W:0]   top;
        logic [REM_W:0]   dif;
        logic [ACC_W-1:0] n_acc;

        always_comb begin
            sh  = {r_acc[k-1], 1'b0};
            top = sh[ACC_W:NUM_W];
            dif = top - {1'b0, r_den[k-1]};
            if (top >= {1'b0, r_den[k-1]}) begin
                n_acc = {dif[REM_W-1:0], sh[NUM_W-1:1], 1'b1};
            end else begin
                n_acc = {top[REM_W-1:0], sh[NUM_W-1:0]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[k] <= n_acc;
                r_den[k] <= r_den[k-1];
                r_neg[k] <= r_neg[k-1];
            end
        end
    end

    assign o_quo = r_acc[QUO_W][QUO_W-1:0];
    assign o_neg = r_neg[QUO_W];

endmodule

// ===== rtl/rbfi_point.sv =====
module rbfi_point (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  rbfi_pkg::t_side             i_side,
    input  logic [rbfi_pkg::PLANES-1:0][rbfi_pkg::QUO_W-1:0] i_tmag,
    input  logic [rbfi_pkg::PLANES-1:0] i_tneg,
    input  rbfi_pkg::t_bounds           i_bnd,
    output logic                        o_valid,
    output logic                        o_hit
);
    import rbfi_pkg::*;

    logic [HI_W-1:0]   r_mhi [PLANES][AXES];
    logic [LO_W-1:0]   r_mlo [PLANES][AXES];
    logic              r_ng  [PLANES][AXES];
    logic [OFF_W:0]    r_off [PLANES][AXES];
    t_side             r_side1;
    t_side             r_side2;
    logic              r_v1;
    logic              r_v2;
    logic              r_v3;
    logic              r_hit;
    logic [PLANES-1:0] in_box;

    // Offset along one axis: product scaled down by 2^16, saturated, signed.
    function automatic logic [OFF_W:0] f_offset(input logic [HI_W-1:0] hi,
                                                input logic [LO_W-1:0] lo,
                                                input logic ng);
        logic [OFF_W-1:0] q;
        if (hi >= HI_W'(64'd1 << LIMIT_LOG)) begin
            q = OFF_SAT;
        end else begin
            q = {1'b0, hi[LIMIT_LOG-1:0], {TSHIFT{1'b0}}}
                + {{(OFF_W-PROD_W+TSHIFT){1'b0}}, lo[PROD_W-1:TSHIFT]};
        end
        return ng ? (~{1'b0, q} + 1'b1) : {1'b0, q};
    endfunction

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Stage one: direction magnitude times each half of t.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int p = 0; p < PLANES; p++) begin
                for (int b = 0; b < AXES; b++) begin
                    r_mhi[p][b] <= HI_W'(i_side.dmag[b] * i_tmag[p][QUO_W-1:TL_W]);
                    r_mlo[p][b] <= LO_W'(i_side.dmag[b] * i_tmag[p][TL_W-1:0]);
                    r_ng[p][b]  <= i_side.dneg[b] ^ i_tneg[p];
                end
            end
            r_side1 <= i_side;
        end
    end

    // Stage two: combine partial products into the signed offset.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int p = 0; p < PLANES; p++) begin
                for (int b = 0; b < AXES; b++) begin
                    r_off[p][b] <= f_offset(r_mhi[p][b], r_mlo[p][b], r_ng[p][b]);
                end
            end
            r_side2 <= r_side1;
        end
    end

    // Stage three: crossing point against the closed box on every axis.
    always_comb begin
        logic [PT_W-1:0] pt;
        logic [PT_W-1:0] lo;
        logic [PT_W-1:0] hi;
        for (int p = 0; p < PLANES; p++) begin
            in_box[p] = 1'b1;
            for (int b = 0; b < AXES; b++) begin
                pt = {{(PT_W-O2_W){r_side2.org2[b][O2_W-1]}}, r_side2.org2[b]}
                     + {{(PT_W-OFF_W-1){r_off[p][b][OFF_W]}}, r_off[p][b]};
                lo = {{(PT_W-BND_W){i_bnd.lo[b][BND_W-1]}}, i_bnd.lo[b]};
                hi = {{(PT_W-BND_W){i_bnd.hi[b][BND_W-1]}}, i_bnd.hi[b]};
                if ($signed(pt) < $signed(lo) || $signed(pt) > $signed(hi)) begin
                    in_box[p] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit <= |(in_box & r_side2.pen);
        end
    end

    assign o_valid = r_v3;
    assign o_hit   = r_hit;

endmodule

// ===== rtl/rbfi_checker.sv =====
module rbfi_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic [rbfi_pkg::COORD_W-1:0]  i_start_x,
    input logic [rbfi_pkg::COORD_W-1:0]  i_start_y,
    input logic [rbfi_pkg::COORD_W-1:0]  i_start_z,
    input logic [rbfi_pkg::COORD_W-1:0]  i_dir_x,
    input logic [rbfi_pkg::COORD_W-1:0]  i_dir_y,
    input logic [rbfi_pkg::COORD_W-1:0]  i_dir_z,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic                          o_hit,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [rbfi_pkg::ADDR_W-1:0]   paddr,
    input logic [rbfi_pkg::DATA_W-1:0]   pwdata,
    input logic [rbfi_pkg::DATA_W-1:0]   prdata,
    input logic                          pready
);

    // A held result keeps its value until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_hit))
        else $error("result changed while stalled");

    // The input side is only held back by a stalled result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held result");

    // The pipeline is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

    // The register port never inserts wait states.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("register port not ready");

endmodule

bind ray_box_face_intersection_core rbfi_checker u_chk (.*);
